>>> hdl/jca_pkg.sv
// shared types and constants for the joystick conditioner
package jca_pkg;

  localparam int BTN_W    = 16;
  localparam int RAW_W    = 11;
  localparam int AXIS_W   = 8;
  localparam int DIR_W    = 4;
  localparam int DZ_W     = 7;
  localparam int CNT_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // merged axis: raw plus or minus one full swing from each button
  localparam int MRG_W    = 13;
  localparam int MAG_W    = 10;
  localparam int Q_W      = 7;

  localparam int AXIS_FULL   = 1000;
  localparam int AXIS_SCALE  = 127;
  localparam int DIR_NEUTRAL = 5;
  localparam int DIR_ROW     = 3;

  // x*127/1000 as x*SCALE_MULT >> SCALE_SHIFT, exact for |x| <= 1000
  localparam int SCALE_SHIFT = 27;
  localparam longint SCALE_MULT = (longint'(AXIS_SCALE) * ((64'd1 << SCALE_SHIFT) / AXIS_FULL + 1));
  localparam int PROD_W = 35;

  localparam int BTN_DOWN  = 0;
  localparam int BTN_LEFT  = 1;
  localparam int BTN_RIGHT = 2;
  localparam int BTN_UP    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 2'd2;

  localparam logic [DZ_W-1:0]  DEAD_ZONE_RST     = 7'd64;
  localparam logic [CNT_W-1:0] FIRST_DELAY_RST   = 8'd20;
  localparam logic [CNT_W-1:0] REPEAT_PERIOD_RST = 8'd4;

  typedef logic [BTN_W-1:0]         btn_t;
  typedef logic signed [RAW_W-1:0]  raw_t;
  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic [DIR_W-1:0]         dir_t;

  typedef struct packed {
    logic           neg;
    logic [Q_W-1:0] mag;
  } cond_axis_t;

endpackage

>>> hdl/jca_in_if.sv
// input channel: one frame tick of buttons and raw stick axes
interface jca_in_if import jca_pkg::*; ();
  logic valid;
  logic ready;
  btn_t buttons;
  raw_t raw_x;
  raw_t raw_y;

  modport source (output valid, output buttons, output raw_x, output raw_y, input ready);
  modport sink   (input valid, input buttons, input raw_x, input raw_y, output ready);
endinterface

>>> hdl/jca_out_if.sv
// result channel: new presses, conditioned axes and digital direction
interface jca_out_if import jca_pkg::*; ();
  logic  valid;
  logic  ready;
  btn_t  new_presses;
  axis_t axis_x;
  axis_t axis_y;
  dir_t  direction;

  modport source (output valid, output new_presses, output axis_x, output axis_y,
                  output direction, input ready);
  modport sink   (input valid, input new_presses, input axis_x, input axis_y,
                  input direction, output ready);
endinterface

>>> hdl/joystick_conditioner_autorepeat.sv
// joystick conditioner with edge detect, axis scaling and typematic repeat
// a beat accepted into the input register moves on to the result register, which drives
//   the result channel; a stall on the result channel holds both registers
// throughput: one beat per cycle while the result channel is ready; the input register
//   and the result register each hand over in the same cycle they take a new beat
// reset (rst_n low, synchronous): both stages empty, button history, repeat latch
//   and hold counter cleared, registers back to dead_zone 64, first_delay 20,
//   repeat_period 4
module joystick_conditioner_autorepeat import jca_pkg::*; #(
  parameter int BUTTON_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  jca_in_if.sink                in_ch,
  jca_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // only the low buttons are tracked; the input field caps it at 16
  localparam int KEEP_W = (BUTTON_BITS < BTN_W) ? BUTTON_BITS : BTN_W;

  localparam logic signed [MRG_W-1:0] MRG_FULL = MRG_W'(AXIS_FULL);
  localparam logic [MAG_W-1:0]        MAG_FULL = MAG_W'(AXIS_FULL);
  localparam logic [PROD_W-1:0]       MULT_K   = PROD_W'(SCALE_MULT);

  // configuration registers
  logic [DZ_W-1:0]  dead_zone_r;
  logic [CNT_W-1:0] first_delay_r;
  logic [CNT_W-1:0] repeat_period_r;

  // input stage
  logic s1_valid_r;
  btn_t s1_buttons_r;
  raw_t s1_raw_x_r;
  raw_t s1_raw_y_r;

  // block state carried from beat to beat
  logic [KEEP_W-1:0] prev_buttons_r, prev_buttons_nxt;
  logic              repeat_latched_r, repeat_latched_nxt;
  logic [CNT_W-1:0]  hold_count_r, hold_count_nxt;

  // result stage
  logic  out_valid_r;
  btn_t  new_presses_r, new_presses_nxt;
  axis_t axis_x_r, axis_x_nxt;
  axis_t axis_y_r, axis_y_nxt;
  dir_t  direction_r, direction_nxt;

  logic advance;
  logic xfer;

  // merge the two buttons into a raw axis, clamp to full swing and scale by 127/1000
  function automatic cond_axis_t condition_axis(input raw_t raw, input logic plus,
                                                input logic minus);
    logic signed [MRG_W-1:0] merged;
    logic [MRG_W-1:0]        abs_val;
    logic [MAG_W-1:0]        mag;
    logic [PROD_W-1:0]       prod;
    cond_axis_t              res;
    merged  = MRG_W'(raw) + (plus ? MRG_FULL : '0) - (minus ? MRG_FULL : '0);
    abs_val = merged[MRG_W-1] ? MRG_W'(-merged) : MRG_W'(merged);
    if (merged >= MRG_FULL || merged <= -MRG_FULL) begin
      mag = MAG_FULL;
    end else begin
      mag = abs_val[MAG_W-1:0];
    end
    // reciprocal multiply stands in for the divide by 1000
    prod    = PROD_W'(mag) * MULT_K;
    res.neg = merged[MRG_W-1];
    res.mag = prod[SCALE_SHIFT +: Q_W];
    return res;
  endfunction

  // a beat moves from the input register to the result register
  assign advance     = !out_valid_r || out_ch.ready;
  assign xfer        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;

  cond_axis_t cx, cy;
  logic [KEEP_W-1:0] btn_k;
  logic x_pos, x_neg, y_pos, y_neg;
  logic released;
  logic [CNT_W:0] next_cnt;
  logic [CNT_W:0] after_rep;
  logic [DIR_W-1:0] dir_col, dir_row;

  always_comb begin
    btn_k = s1_buttons_r[KEEP_W-1:0];
    cx = condition_axis(s1_raw_x_r, s1_buttons_r[BTN_RIGHT], s1_buttons_r[BTN_LEFT]);
    // positive y is down
    cy = condition_axis(s1_raw_y_r, s1_buttons_r[BTN_DOWN], s1_buttons_r[BTN_UP]);

    // edge detect against the previous tick
    new_presses_nxt  = BTN_W'(btn_k & ~prev_buttons_r);
    prev_buttons_nxt = btn_k;

    axis_x_nxt = cx.neg ? -AXIS_W'(cx.mag) : AXIS_W'(cx.mag);
    axis_y_nxt = cy.neg ? -AXIS_W'(cy.mag) : AXIS_W'(cy.mag);

    // beyond the dead zone in either sense, from sign and magnitude
    x_pos = !cx.neg && (cx.mag > dead_zone_r);
    x_neg =  cx.neg && (cx.mag > dead_zone_r);
    y_pos = !cy.neg && (cy.mag > dead_zone_r);
    y_neg =  cy.neg && (cy.mag > dead_zone_r);

    // numpad layout: right adds one, up adds a row
    dir_col = x_pos ? DIR_W'(DIR_NEUTRAL + 1) :
              x_neg ? DIR_W'(DIR_NEUTRAL - 1) : DIR_W'(DIR_NEUTRAL);
    dir_row = y_neg ? DIR_W'(DIR_ROW) : '0;
    if (repeat_latched_r) begin
      direction_nxt = DIR_W'(DIR_NEUTRAL);
    end else if (y_pos) begin
      direction_nxt = dir_col - DIR_W'(DIR_ROW);
    end else begin
      direction_nxt = dir_col + dir_row;
    end

    // hold counter: clear inside the dead zone, else count toward the next repeat
    released  = (cx.mag < dead_zone_r) && (cy.mag < dead_zone_r);
    next_cnt  = {1'b0, hold_count_r} + (CNT_W+1)'(1);
    after_rep = (next_cnt >= {1'b0, repeat_period_r}) ?
                next_cnt - {1'b0, repeat_period_r} : '0;
    if (released) begin
      repeat_latched_nxt = 1'b0;
      hold_count_nxt     = '0;
    end else if (next_cnt >= {1'b0, first_delay_r}) begin
      // repeat fires: step back one period and let the direction through
      repeat_latched_nxt = 1'b0;
      hold_count_nxt     = after_rep[CNT_W] ? '1 : after_rep[CNT_W-1:0];
    end else begin
      repeat_latched_nxt = 1'b1;
      hold_count_nxt     = next_cnt[CNT_W] ? '1 : next_cnt[CNT_W-1:0];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r     <= DEAD_ZONE_RST;
      first_delay_r   <= FIRST_DELAY_RST;
      repeat_period_r <= REPEAT_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEAD_ZONE:     dead_zone_r     <= cfg_wdata[DZ_W-1:0];
        CFG_FIRST_DELAY:   first_delay_r   <= cfg_wdata[CNT_W-1:0];
        CFG_REPEAT_PERIOD: repeat_period_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      prev_buttons_r   <= '0;
      repeat_latched_r <= 1'b0;
      hold_count_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (xfer) begin
        prev_buttons_r   <= prev_buttons_nxt;
        repeat_latched_r <= repeat_latched_nxt;
        hold_count_r     <= hold_count_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_buttons_r <= in_ch.buttons;
      s1_raw_x_r   <= in_ch.raw_x;
      s1_raw_y_r   <= in_ch.raw_y;
    end
    if (xfer) begin
      new_presses_r <= new_presses_nxt;
      axis_x_r      <= axis_x_nxt;
      axis_y_r      <= axis_y_nxt;
      direction_r   <= direction_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.new_presses = new_presses_r;
  assign out_ch.axis_x      = axis_x_r;
  assign out_ch.axis_y      = axis_y_r;
  assign out_ch.direction   = direction_r;

  // latch only holds while the counter is running
  a_latch_count: assert property (@(posedge clk) disable iff (!rst_n)
    repeat_latched_r |-> (hold_count_r != '0))
    else $error("repeat latch set with zero hold count");

  // state moves only when a beat passes into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !xfer |=> $stable(hold_count_r) && $stable(repeat_latched_r))
    else $error("repeat state changed without a beat");

  // an empty result register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty result register");

  // direction stays on the keypad
  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (direction_r >= DIR_W'(1)) && (direction_r <= DIR_W'(9)))
    else $error("direction off the keypad");

  // scaled axes never reach the most negative code
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (axis_x_r != axis_t'(-128)) && (axis_y_r != axis_t'(-128)))
    else $error("scaled axis out of range");

endmodule

>>> test/joystick_conditioner_autorepeat_tb.sv
// testbench for the joystick conditioner: directed and random ticks checked against a predictor
module joystick_conditioner_autorepeat_tb;
  import jca_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // two pipeline stages; idle edges added after every expected result is out
  localparam int DRAIN_CYCLES   = 4;
  // cycles with no beat on either channel before the run is declared hung
  localparam int STALL_LIMIT    = 2000;
  localparam int RAND_PHASES    = 8;
  localparam int RAND_PER_PHASE = 235;

  // one conditioned tick as the result channel carries it
  typedef struct packed {
    btn_t  new_presses;
    axis_t axis_x;
    axis_t axis_y;
    dir_t  direction;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  jca_in_if  in_ch ();
  jca_out_if out_ch ();

  joystick_conditioner_autorepeat dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // predictor copy of the registers
  logic [DZ_W-1:0]  dz_set;
  logic [CNT_W-1:0] delay_set;
  logic [CNT_W-1:0] period_set;

  // predictor copy of the block state
  btn_t             last_btns;
  logic             repeat_hold;
  logic [CNT_W-1:0] hold_ticks;

  tick_result_t pending_ticks[$];
  int           mismatches = 0;
  int           ticks_sent = 0;
  // set during the phase that runs with no idle cycles on either side
  logic         steady = 1'b0;

  // clamp to one full swing, then scale to 127 with truncation toward zero
  function automatic int scale_axis(input int v);
    if (v < -AXIS_FULL) v = -AXIS_FULL;
    if (v > AXIS_FULL) v = AXIS_FULL;
    return (v * AXIS_SCALE) / AXIS_FULL;
  endfunction

  // expected result of one tick; advances the predictor state
  function automatic tick_result_t condition_tick(input btn_t btns, input raw_t rx,
                                                  input raw_t ry);
    tick_result_t res;
    int x, y, dz, dir, nxt;
    x = int'(rx);
    y = int'(ry);
    dz = int'(dz_set);
    dir = DIR_NEUTRAL;
    res.new_presses = btns & ~last_btns;
    last_btns = btns;

    // direction buttons push the axes a full swing each way
    if (btns[BTN_UP]) y -= AXIS_FULL;
    if (btns[BTN_DOWN]) y += AXIS_FULL;
    if (btns[BTN_LEFT]) x -= AXIS_FULL;
    if (btns[BTN_RIGHT]) x += AXIS_FULL;
    x = scale_axis(x);
    y = scale_axis(y);

    // numpad direction only while the repeat latch is open
    if (!repeat_hold) begin
      if (x > dz) dir += 1;
      if (x < -dz) dir -= 1;
      if (y > dz) dir -= DIR_ROW;
      if (y < -dz) dir += DIR_ROW;
    end

    // both axes inside the dead zone release everything
    if ((x < 0 ? -x : x) < dz && (y < 0 ? -y : y) < dz) begin
      repeat_hold = 1'b0;
      hold_ticks = '0;
    end else begin
      nxt = int'(hold_ticks) + 1;
      repeat_hold = 1'b1;
      if (nxt >= int'(delay_set)) begin
        // step back by one period, never below zero, and open the latch
        nxt = (nxt >= int'(period_set)) ? nxt - int'(period_set) : 0;
        repeat_hold = 1'b0;
      end
      hold_ticks = (nxt > 255) ? 8'd255 : CNT_W'(nxt);
    end

    res.axis_x = axis_t'(x);
    res.axis_y = axis_t'(y);
    res.direction = dir_t'(dir);
    return res;
  endfunction

  // a gap with odds of 24 in a hundred per roll unless the steady phase is running
  function automatic logic gap_roll();
    return !steady && ($urandom_range(99) < 24);
  endfunction

  // one input beat, with a random gap in front; valid stays up after the beat
  task automatic send_tick(input btn_t btns, input raw_t rx, input raw_t ry);
    while (gap_roll()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.buttons <= btns;
    in_ch.raw_x   <= rx;
    in_ch.raw_y   <= ry;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_ticks.push_back(condition_tick(btns, rx, ry));
    ticks_sent++;
  endtask

  // stop sending and wait until every expected result has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all three registers while the block is idle
  task automatic write_config(input logic [DZ_W-1:0] dz, input logic [CNT_W-1:0] fd,
                              input logic [CNT_W-1:0] rp);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEAD_ZONE;
    cfg_wdata <= CFG_DATA_W'(dz);
    @(posedge clk);
    dz_set = dz;
    cfg_index <= CFG_FIRST_DELAY;
    cfg_wdata <= fd;
    @(posedge clk);
    delay_set = fd;
    cfg_index <= CFG_REPEAT_PERIOD;
    cfg_wdata <= rp;
    @(posedge clk);
    period_set = rp;
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // raw stick value for a held gesture, kept within one full swing
  function automatic raw_t hold_axis(input logic [DZ_W-1:0] dz);
    int b;
    case ($urandom_range(3))
      0: b = int'($urandom_range(2000)) - 1000;
      1: b = $urandom_range(1) ? AXIS_FULL : -AXIS_FULL;
      2: begin
        // hover around the dead zone edge
        b = (int'(dz) * AXIS_FULL) / AXIS_SCALE + int'($urandom_range(16)) - 8;
        if ($urandom_range(1)) b = -b;
      end
      default: b = 0;
    endcase
    if (b > AXIS_FULL) b = AXIS_FULL;
    if (b < -AXIS_FULL) b = -AXIS_FULL;
    return raw_t'(b);
  endfunction

  // power-on registers: extremes of every field, clamping, edge detect, rounding
  task automatic test_power_on_defaults();
    send_tick('0, '0, '0);
    send_tick(16'hFFFF, '0, '0);           // opposing buttons cancel
    send_tick('0, 11'sh3FF, 11'sh400);     // raw beyond one full swing
    send_tick('0, -11'sd1000, 11'sd1000);  // latch holds the direction back
    send_tick('0, '0, '0);
    send_tick(btn_t'(1) << BTN_UP, '0, '0);
    send_tick((btn_t'(1) << BTN_LEFT) | (btn_t'(1) << BTN_DOWN), '0, '0);
    send_tick(btn_t'(1) << BTN_RIGHT, 11'sd1000, 11'sd7);  // merged sum clamps
    send_tick(16'hAAAA, -11'sd8, 11'sd8);  // single direction buttons add a full swing to small raw values
    send_tick(16'h5555, 11'sd8, -11'sd7);
  endtask

  // short delay and period so first repeat and later repeats fall in a few ticks
  task automatic test_repeat_cadence();
    write_config(7'd10, 8'd4, 8'd2);
    repeat (7) send_tick('0, 11'sd1000, '0);
    send_tick('0, '0, '0);
    repeat (3) send_tick((btn_t'(1) << BTN_UP) | (btn_t'(1) << BTN_LEFT), '0, '0);
  endtask

  // zero dead zone: a centered stick never releases, counter keeps running
  task automatic test_zero_dead_zone();
    write_config(7'd0, 8'd3, 8'd1);
    repeat (4) send_tick('0, '0, '0);
  endtask

  // period larger than the count floors at zero; widest dead zone
  task automatic test_period_over_delay();
    write_config(7'd127, 8'd2, 8'd255);
    repeat (4) send_tick('0, -11'sd1000, '0);
    send_tick('0, -11'sd999, '0);
  endtask

  // mostly held gestures with random content, the rest raw noise
  task automatic test_random_gestures();
    int phase, target, len, k, n;
    logic [DZ_W-1:0]  dz;
    logic [CNT_W-1:0] fd, rp;
    btn_t pad, upper;
    raw_t bx, by;
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        1: begin
          dz = '0; fd = 8'd1; rp = 8'd1;
        end
        2: begin
          dz = 7'd127; fd = 8'd255; rp = 8'd255;
        end
        5: begin
          dz = 7'd5; fd = 8'd255; rp = 8'd1;
        end
        default: begin
          dz = DZ_W'($urandom_range(127));
          fd = ($urandom_range(3) == 0) ? CNT_W'($urandom_range(255, 1)) :
                                          CNT_W'($urandom_range(24, 1));
          rp = ($urandom_range(4) == 0) ? CNT_W'($urandom_range(255, 1)) :
                                          CNT_W'($urandom_range(fd, 1));
        end
      endcase
      write_config(dz, fd, rp);
      steady = (phase == 3);
      target = ticks_sent + RAND_PER_PHASE;
      upper = '0;
      while (ticks_sent < target) begin
        if ($urandom_range(99) < 25) begin
          // noise: every bit of every field free
          send_tick(btn_t'($urandom()), raw_t'($urandom()), raw_t'($urandom()));
        end else begin
          pad = ($urandom_range(1) == 0) ? '0 : btn_t'($urandom_range(15));
          bx = hold_axis(dz);
          by = hold_axis(dz);
          // long holds only where the first delay needs them
          if (fd > 40 && $urandom_range(2) == 0) len = int'(fd) + int'(rp) + 2;
          else len = $urandom_range(40, 1);
          if (len > 300) len = 300;
          // the last gesture of a phase ends with the phase
          if (len > target - ticks_sent) len = target - ticks_sent;
          for (k = 0; k < len; k++) begin
            if ($urandom_range(3) == 0) upper = btn_t'($urandom()) & 16'hFFF0;
            send_tick(upper | pad,
                      raw_t'(int'(bx) + int'($urandom_range(16)) - 8),
                      raw_t'(int'(by) + int'($urandom_range(16)) - 8));
          end
          // let go for up to three ticks, which clears the latch when the dead zone is wide enough
          n = $urandom_range(3);
          for (k = 0; k < n; k++)
            send_tick(upper, raw_t'(int'($urandom_range(16)) - 8), '0);
        end
      end
    end
    steady = 1'b0;
  endtask

  // result side: random stalls, steady phase never stalls
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !gap_roll();
    end
  end

  // every result beat against the oldest expectation
  always @(posedge clk) begin : check_results
    tick_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_ticks.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %0h %0h %0h %0h", $time,
                 out_ch.new_presses, out_ch.axis_x, out_ch.axis_y, out_ch.direction);
        mismatches++;
      end else begin
        want = pending_ticks.pop_front();
        check_field("new_presses", want.new_presses, out_ch.new_presses);
        check_field("axis_x", 16'(want.axis_x), 16'(out_ch.axis_x));
        check_field("axis_y", 16'(want.axis_y), 16'(out_ch.axis_y));
        check_field("direction", 16'(want.direction), 16'(out_ch.direction));
      end
    end
  end

  // hang detector: too long with no beat on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_DEAD_ZONE;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.buttons <= '0;
    in_ch.raw_x   <= '0;
    in_ch.raw_y   <= '0;

    // predictor mirrors the reset state
    dz_set      = DEAD_ZONE_RST;
    delay_set   = FIRST_DELAY_RST;
    period_set  = REPEAT_PERIOD_RST;
    last_btns   = '0;
    repeat_hold = 1'b0;
    hold_ticks  = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_on_defaults();
    test_repeat_cadence();
    test_zero_dead_zone();
    test_period_over_delay();
    test_random_gestures();

    drain();
    if (mismatches == 0 && pending_ticks.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> joystick_conditioner_autorepeat.f
hdl/jca_pkg.sv
hdl/jca_in_if.sv
hdl/jca_out_if.sv
hdl/joystick_conditioner_autorepeat.sv
test/joystick_conditioner_autorepeat_tb.sv
